/* hw/rtl/thab_pkg.sv */
`default_nettype none

package thab_pkg;

    localparam int unsigned LANES        = 6;
    localparam int unsigned SAMPLE_W     = 8;
    localparam int unsigned WEIGHT_W     = 9;
    localparam int unsigned IMG_W        = 11;
    localparam int unsigned SPROD_W      = 20;
    localparam int unsigned CPROD_W      = 17;
    localparam int unsigned SUM_W        = 21;
    localparam int unsigned LUMA_SHIFT   = 6;
    localparam int unsigned CHROMA_SHIFT = 7;

    localparam logic [7:0] LUMA_FULL   = 8'd64;
    localparam logic [7:0] CHROMA_FULL = 8'd128;
    localparam logic [7:0] SAT_MAX     = 8'd255;

    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_TEXT_COLOR   = 2'd1;
    localparam logic [1:0] REG_HALO_COLOR   = 2'd2;

    typedef enum logic [1:0] {
        FMT_RGB24 = 2'd0,
        FMT_RGB32 = 2'd1,
        FMT_YUY2  = 2'd2,
        FMT_YV12  = 2'd3
    } fmt_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0] ct;
        logic [SAMPLE_W-1:0] ch;
        logic [WEIGHT_W-1:0] at;
        logic [WEIGHT_W-1:0] ah;
        logic                chroma;
    } lane_t;

    typedef struct packed {
        logic signed [SPROD_W-1:0] sp;
        logic [CPROD_W-1:0]        tp;
        logic [CPROD_W-1:0]        hp;
        logic                      chroma;
    } prod_t;

    typedef lane_t [LANES-1:0] lane_vec_t;
    typedef prod_t [LANES-1:0] prod_vec_t;
    typedef logic [LANES-1:0][SAMPLE_W-1:0] sample_vec_t;

endpackage

`default_nettype wire

/* hw/rtl/thab_if.sv */
`default_nettype none

interface thab_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sample_a;
    logic [7:0]  sample_b;
    logic [7:0]  sample_c;
    logic [7:0]  sample_d;
    logic [7:0]  sample_e;
    logic [7:0]  sample_f;
    logic [31:0] mask_row_top;
    logic [31:0] mask_row_bottom;

    modport source (
        output valid, sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
               mask_row_top, mask_row_bottom,
        input  ready
    );
    modport sink (
        input  valid, sample_a, sample_b, sample_c, sample_d, sample_e, sample_f,
               mask_row_top, mask_row_bottom,
        output ready
    );
endinterface

interface thab_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic [7:0] out_d;
    logic [7:0] out_e;
    logic [7:0] out_f;

    modport source (
        output valid, out_a, out_b, out_c, out_d, out_e, out_f,
        input  ready
    );
    modport sink (
        input  valid, out_a, out_b, out_c, out_d, out_e, out_f,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/text_halo_alpha_blend.sv */
// Text and halo alpha blend over video sample groups.
//
// Input channel "pixels" carries six samples and two rows of mask bytes;
// output channel "blended" carries the six blended samples. One transfer
// happens at each rising edge where valid and ready are both high.
// The user must write registers (pixel format, text color, halo color) via
// wr_en / wr_index / wr_data only while no item is in flight; not enforced.
//
// Three register stages: lane decode, multiply, sum and saturate. One item
// is taken every cycle while the output is not stalled. Each stage holds
// while the stage behind it is full and stalled, so when the receiver drops
// ready the pipeline fills up and then pixels.ready falls; nothing is
// dropped or repeated.
//
// Reset (rst_n low, asynchronous) empties the pipeline and sets RGB24,
// white text and black halo.
`default_nettype none

module text_halo_alpha_blend (
    input  wire logic       clk,
    input  wire logic       rst_n,
    thab_in_if.sink         pixels,
    thab_out_if.source      blended,
    input  wire logic       wr_en,
    input  wire logic [1:0] wr_index,
    input  wire logic [23:0] wr_data
);
    import thab_pkg::*;

    fmt_t        fmt_reg;
    logic [23:0] text_color_reg;
    logic [23:0] halo_color_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    sample_vec_t samples;
    lane_vec_t   lanes_next, lanes_reg;
    prod_vec_t   prods_next, prods_reg;
    sample_vec_t res_next, res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= FMT_RGB24;
            text_color_reg <= 24'hFFFFFF;
            halo_color_reg <= 24'h000000;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PIXEL_FORMAT: fmt_reg        <= fmt_t'(wr_data[1:0]);
                REG_TEXT_COLOR:   text_color_reg <= wr_data;
                REG_HALO_COLOR:   halo_color_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    assign rdy3 = !v3_reg || blended.ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pixels.ready = rdy1;

    assign samples[0] = pixels.sample_a;
    assign samples[1] = pixels.sample_b;
    assign samples[2] = pixels.sample_c;
    assign samples[3] = pixels.sample_d;
    assign samples[4] = pixels.sample_e;
    assign samples[5] = pixels.sample_f;

    thab_decode u_decode (
        .fmt        (fmt_reg),
        .text_color (text_color_reg),
        .halo_color (halo_color_reg),
        .samples    (samples),
        .top        (pixels.mask_row_top),
        .bot        (pixels.mask_row_bottom),
        .lanes      (lanes_next)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        thab_mul u_mul (
            .lane (lanes_reg[g]),
            .prod (prods_next[g])
        );
        thab_sat u_sat (
            .prod   (prods_reg[g]),
            .result (res_next[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= pixels.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pixels.valid)
            lanes_reg <= lanes_next;
        if (rdy2 && v1_reg)
            prods_reg <= prods_next;
        if (rdy3 && v2_reg)
            res_reg <= res_next;
    end

    assign blended.valid = v3_reg;
    assign blended.out_a = res_reg[0];
    assign blended.out_b = res_reg[1];
    assign blended.out_c = res_reg[2];
    assign blended.out_d = res_reg[3];
    assign blended.out_e = res_reg[4];
    assign blended.out_f = res_reg[5];

endmodule

`default_nettype wire

/* hw/rtl/thab_decode.sv */
`default_nettype none

module thab_decode (
    input  wire thab_pkg::fmt_t        fmt,
    input  wire logic [23:0]           text_color,
    input  wire logic [23:0]           halo_color,
    input  wire thab_pkg::sample_vec_t samples,
    input  wire logic [31:0]           top,
    input  wire logic [31:0]           bot,
    output thab_pkg::lane_vec_t        lanes
);
    import thab_pkg::*;

    logic [7:0] t_hi, t_md, t_lo, h_hi, h_md, h_lo;
    logic [7:0] m0, m1, m2, m3, b0, b1, b2, b3;
    logic [8:0] yuy_wt, yuy_wh;
    logic [9:0] yv_st, yv_sh;

    assign t_hi = text_color[23:16];
    assign t_md = text_color[15:8];
    assign t_lo = text_color[7:0];
    assign h_hi = halo_color[23:16];
    assign h_md = halo_color[15:8];
    assign h_lo = halo_color[7:0];
    assign m0 = top[7:0];
    assign m1 = top[15:8];
    assign m2 = top[23:16];
    assign m3 = top[31:24];
    assign b0 = bot[7:0];
    assign b1 = bot[15:8];
    assign b2 = bot[23:16];
    assign b3 = bot[31:24];

    assign yuy_wt = 9'(m0) + 9'(m2);
    assign yuy_wh = 9'(m1) + 9'(m3);
    assign yv_st  = 10'(m0) + 10'(m2) + 10'(b0) + 10'(b2);
    assign yv_sh  = 10'(m1) + 10'(m3) + 10'(b1) + 10'(b3);

    // zero weights on the luma scale give the sample back unchanged
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lanes[i].s      = samples[i];
            lanes[i].ct     = '0;
            lanes[i].ch     = '0;
            lanes[i].at     = '0;
            lanes[i].ah     = '0;
            lanes[i].chroma = 1'b0;
        end
        case (fmt)
            FMT_RGB24, FMT_RGB32:
            begin
                lanes[0].ct = t_lo; lanes[0].ch = h_lo;
                lanes[1].ct = t_md; lanes[1].ch = h_md;
                lanes[2].ct = t_hi; lanes[2].ch = h_hi;
                for (int i = 0; i < 3; i++)
                begin
                    lanes[i].at = 9'(m0);
                    lanes[i].ah = 9'(m1);
                end
            end
            FMT_YUY2:
            begin
                lanes[0].ct = t_hi; lanes[0].ch = h_hi;
                lanes[0].at = 9'(m0); lanes[0].ah = 9'(m1);
                lanes[2].ct = t_hi; lanes[2].ch = h_hi;
                lanes[2].at = 9'(m2); lanes[2].ah = 9'(m3);
                lanes[1].ct = t_md; lanes[1].ch = h_md;
                lanes[3].ct = t_lo; lanes[3].ch = h_lo;
                lanes[1].at = yuy_wt; lanes[1].ah = yuy_wh; lanes[1].chroma = 1'b1;
                lanes[3].at = yuy_wt; lanes[3].ah = yuy_wh; lanes[3].chroma = 1'b1;
            end
            FMT_YV12:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lanes[i].ct = t_hi;
                    lanes[i].ch = h_hi;
                end
                lanes[0].at = 9'(m0); lanes[0].ah = 9'(m1);
                lanes[1].at = 9'(m2); lanes[1].ah = 9'(m3);
                lanes[2].at = 9'(b0); lanes[2].ah = 9'(b1);
                lanes[3].at = 9'(b2); lanes[3].ah = 9'(b3);
                lanes[4].ct = t_md; lanes[4].ch = h_md;
                lanes[5].ct = t_lo; lanes[5].ch = h_lo;
                lanes[4].at = yv_st[9:1]; lanes[4].ah = yv_sh[9:1]; lanes[4].chroma = 1'b1;
                lanes[5].at = yv_st[9:1]; lanes[5].ah = yv_sh[9:1]; lanes[5].chroma = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/thab_mul.sv */
`default_nettype none

module thab_mul (
    input  wire thab_pkg::lane_t lane,
    output thab_pkg::prod_t      prod
);
    import thab_pkg::*;

    logic [7:0]              full;
    logic signed [IMG_W-1:0] img;

    assign full = lane.chroma ? CHROMA_FULL : LUMA_FULL;
    assign img  = $signed(IMG_W'(full) - IMG_W'(lane.at) - IMG_W'(lane.ah));

    assign prod.sp     = SPROD_W'($signed({1'b0, lane.s})) * SPROD_W'(img);
    assign prod.tp     = CPROD_W'(lane.ct) * CPROD_W'(lane.at);
    assign prod.hp     = CPROD_W'(lane.ch) * CPROD_W'(lane.ah);
    assign prod.chroma = lane.chroma;

endmodule

`default_nettype wire

/* hw/rtl/thab_sat.sv */
`default_nettype none

module thab_sat (
    input  wire thab_pkg::prod_t prod,
    output logic [7:0]           result
);
    import thab_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        shifted;

    assign sum = SUM_W'(prod.sp) + $signed({4'b0, prod.tp}) + $signed({4'b0, prod.hp});
    assign shifted = prod.chroma ? (SUM_W'(sum) >> CHROMA_SHIFT)
                                 : (SUM_W'(sum) >> LUMA_SHIFT);

    always_comb
    begin
        if (sum[SUM_W-1])
            result = '0;
        else if (shifted > SUM_W'(SAT_MAX))
            result = SAT_MAX;
        else
            result = shifted[7:0];
    end

endmodule

`default_nettype wire
